>>> hdl/dct_pkg.sv
// ----------------------------------------------------------------------------
// dct_pkg: shared types and constants for the delayed coincidence tagger
// Field widths, hit-class bit positions and the transaction records that pass
// between the front, the internal queues and the back.
// ----------------------------------------------------------------------------
package dct_pkg;

  localparam int SEG_W  = 4;
  localparam int TIME_W = 48;
  localparam int CLS_W  = 7;
  localparam int REG_W  = 24;
  localparam int PC_W   = 4;
  localparam int AC_W   = 8;

  localparam int HIT_IONI_BIT   = 0;
  localparam int HIT_RECOIL_BIT = 2;

  // Internal queue depth (power of two).
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    REG_NEAR_START = 2'd0,
    REG_NEAR_END   = 2'd1,
    REG_FAR_BEGIN  = 2'd2,
    REG_FAR_LIMIT  = 2'd3
  } cfg_reg_e;

  // Classified pulse, front to back.
  typedef struct packed {
    logic [SEG_W-1:0]  seg;
    logic [TIME_W-1:0] ptime;
    logic              ioni;
    logic              recoil;
  } item_t;

  // Closed candidate record.
  typedef struct packed {
    logic [SEG_W-1:0]  seg;
    logic [TIME_W-1:0] prompt;
    logic [PC_W-1:0]   dcount;
    logic [AC_W-1:0]   fcount;
  } rec_t;

endpackage

>>> hdl/delayed_coincidence_tagger_unit.sv
// ----------------------------------------------------------------------------
// delayed_coincidence_tagger_unit: per-segment prompt/delayed pair tagger
// Queue-style pulse input, queue-style record output, plain register writes.
// ----------------------------------------------------------------------------
// Pulses arrive in time order, one transaction per cycle (push while full is
// low). Each segment arms on an ionization hit, counts recoil partners in the
// near window (near_start, near_end), then either disarms, closes at once, or
// enters the far window and counts same-segment pulses in (far_begin,
// far_limit). The first same-segment pulse at or beyond far_limit closes the
// candidate: one record (segment, prompt time, delayed count, far count) is
// queued and the closing pulse is then treated as a pulse on an idle segment.
// Pulses of segments at or above NUM_SEGMENTS are dropped. Throughput is one
// pulse per clock while the result queue is not full: the back end computes the
// whole segment-state update (one 49-bit subtract plus window compares)
// combinationally. An accepted pulse is held in the item queue until the back
// end takes it; as it takes the pulse, the back end writes its record, if any,
// into the result queue, from which the record is shown on the output ports
// until popped. A two-entry queue between front and back and a two-entry
// result queue let either side stall without losing a transaction; full rises
// only when the result side has been stalled long enough to fill both.
// Registers reset to 10000, 502000, 2142000 and 4110000 ns and should be
// written only while no pulse is in flight.
// ----------------------------------------------------------------------------
module delayed_coincidence_tagger_unit
  import dct_pkg::*;
#(
  parameter int NUM_SEGMENTS = 16,
  parameter int MAX_PARTNERS = 15
) (
  input  logic              clk,
  input  logic              rst,
  // pulse input
  input  logic              push,
  output logic              full,
  input  logic [SEG_W-1:0]  segment,
  input  logic [TIME_W-1:0] pulse_time,
  input  logic [CLS_W-1:0]  hit_class,
  // record output
  output logic              empty,
  input  logic              pop,
  output logic [SEG_W-1:0]  out_segment,
  output logic [TIME_W-1:0] prompt_time,
  output logic [PC_W-1:0]   delayed_count,
  output logic [AC_W-1:0]   far_count,
  // register writes
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [REG_W-1:0]  cfg_data
);

  // front -> item queue
  logic  mq_push;
  item_t mq_wdata;
  logic  mq_full;
  // item queue -> back
  logic  mq_pop;
  item_t mq_rdata;
  logic  mq_empty;
  // back -> result queue
  logic  rq_push;
  rec_t  rq_wdata;
  logic  rq_full;
  rec_t  rq_rdata;

  dct_front #(
    .NUM_SEGMENTS (NUM_SEGMENTS)
  ) u_front (
    .push       (push),
    .full       (full),
    .segment    (segment),
    .pulse_time (pulse_time),
    .hit_class  (hit_class),
    .q_full     (mq_full),
    .q_push     (mq_push),
    .q_item     (mq_wdata)
  );

  dct_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mq_push),
    .wdata (mq_wdata),
    .full  (mq_full),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .empty (mq_empty)
  );

  dct_back #(
    .NUM_SEGMENTS (NUM_SEGMENTS),
    .MAX_PARTNERS (MAX_PARTNERS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (mq_empty),
    .q_item    (mq_rdata),
    .q_pop     (mq_pop),
    .out_full  (rq_full),
    .rec_push  (rq_push),
    .rec       (rq_wdata)
  );

  dct_fifo #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_rec_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .wdata (rq_wdata),
    .full  (rq_full),
    .pop   (pop),
    .rdata (rq_rdata),
    .empty (empty)
  );

  assign out_segment   = rq_rdata.seg;
  assign prompt_time   = rq_rdata.prompt;
  assign delayed_count = rq_rdata.dcount;
  assign far_count     = rq_rdata.fcount;

endmodule

>>> hdl/dct_fifo.sv
// ----------------------------------------------------------------------------
// dct_fifo: small synchronous queue
// Push/full on one side, pop/empty on the other; head shown while not empty.
// ----------------------------------------------------------------------------
module dct_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/dct_front.sv
// ----------------------------------------------------------------------------
// dct_front: pulse intake and classification
// Drops pulses of segments outside the array, decodes the hit-class flags.
// ----------------------------------------------------------------------------
module dct_front
  import dct_pkg::*;
#(
  parameter int NUM_SEGMENTS = 16
) (
  input  logic              push,
  output logic              full,
  input  logic [SEG_W-1:0]  segment,
  input  logic [TIME_W-1:0] pulse_time,
  input  logic [CLS_W-1:0]  hit_class,
  input  logic              q_full,
  output logic              q_push,
  output item_t             q_item
);

  logic in_range;

  assign in_range = ({5'd0, segment} < 9'(NUM_SEGMENTS));
  assign full     = q_full;
  assign q_push   = push && !q_full && in_range;

  always_comb begin
    q_item.seg    = segment;
    q_item.ptime  = pulse_time;
    q_item.ioni   = hit_class[HIT_IONI_BIT];
    q_item.recoil = hit_class[HIT_RECOIL_BIT];
  end

endmodule

>>> hdl/dct_back.sv
// ----------------------------------------------------------------------------
// dct_back: per-segment candidate tracking
// One read-modify-write of the segment state per pulse; emits closed records.
// ----------------------------------------------------------------------------
module dct_back
  import dct_pkg::*;
#(
  parameter int NUM_SEGMENTS = 16,
  parameter int MAX_PARTNERS = 15
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  input  logic             q_empty,
  input  item_t            q_item,
  output logic             q_pop,
  input  logic             out_full,
  output logic             rec_push,
  output rec_t             rec
);

  localparam int NSEG  = (NUM_SEGMENTS < (1 << SEG_W)) ? NUM_SEGMENTS : (1 << SEG_W);
  localparam int IDX_W = (NSEG > 1) ? $clog2(NSEG) : 1;
  localparam logic [PC_W-1:0] PCAP = PC_W'((MAX_PARTNERS < 15) ? MAX_PARTNERS : 15);
  localparam logic [AC_W-1:0] ACAP = '1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ARMED = 2'd1,
    PH_FAR   = 2'd2
  } phase_e;

  logic [REG_W-1:0] near_start;
  logic [REG_W-1:0] near_end;
  logic [REG_W-1:0] far_begin;
  logic [REG_W-1:0] far_limit;

  phase_e            phase      [NSEG];
  logic [TIME_W-1:0] armed_time [NSEG];
  logic [PC_W-1:0]   pcount     [NSEG];
  logic [AC_W-1:0]   acount     [NSEG];

  logic [IDX_W-1:0]  idx;
  phase_e            ph;
  logic [TIME_W-1:0] at;
  logic [PC_W-1:0]   pc;
  logic [AC_W-1:0]   ac;
  logic [TIME_W:0]   diff;
  logic [TIME_W-1:0] d;
  logic              early;
  logic              gt_ns, lt_ne, gt_ne, ge_fl, far_in;

  phase_e            ph_next;
  logic              at_load;
  logic [PC_W-1:0]   pc_next;
  logic [AC_W-1:0]   ac_next;
  logic              emit;
  logic [PC_W-1:0]   rec_pc;
  logic [AC_W-1:0]   rec_ac;

  assign q_pop = !q_empty && !out_full;
  assign idx   = q_item.seg[IDX_W-1:0];
  assign ph    = phase[idx];
  assign at    = armed_time[idx];
  assign pc    = pcount[idx];
  assign ac    = acount[idx];

  assign diff   = {1'b0, q_item.ptime} - {1'b0, at};
  assign early  = diff[TIME_W];
  assign d      = diff[TIME_W-1:0];
  assign gt_ns  = d > {{(TIME_W-REG_W){1'b0}}, near_start};
  assign lt_ne  = d < {{(TIME_W-REG_W){1'b0}}, near_end};
  assign gt_ne  = d > {{(TIME_W-REG_W){1'b0}}, near_end};
  assign ge_fl  = d >= {{(TIME_W-REG_W){1'b0}}, far_limit};
  assign far_in = (d > {{(TIME_W-REG_W){1'b0}}, far_begin}) && !ge_fl;

  always_comb begin
    ph_next = ph;
    at_load = 1'b0;
    pc_next = pc;
    ac_next = ac;
    emit    = 1'b0;
    rec_pc  = pc;
    rec_ac  = ac;
    case (ph)
      PH_FAR: begin
        if (!early) begin
          if (!ge_fl) begin
            if (far_in && ac != ACAP) begin
              ac_next = ac + 1'b1;
            end
          end else begin
            // close, then treat the closing pulse as one on an idle segment
            emit    = 1'b1;
            ph_next = q_item.ioni ? PH_ARMED : PH_IDLE;
            at_load = q_item.ioni;
            pc_next = '0;
            ac_next = '0;
          end
        end
      end
      PH_ARMED: begin
        if (q_item.recoil && !early) begin
          if (gt_ns && lt_ne && pc < PCAP) begin
            pc_next = pc + 1'b1;
          end
          if (gt_ne) begin
            if (pc == '0) begin
              ph_next = PH_IDLE;
              ac_next = '0;
            end else if (ge_fl) begin
              emit    = 1'b1;
              rec_ac  = '0;
              ph_next = PH_IDLE;
              pc_next = '0;
              ac_next = '0;
            end else begin
              ph_next = PH_FAR;
              ac_next = far_in ? AC_W'(1) : '0;
            end
          end
        end
      end
      default: begin
        if (q_item.ioni) begin
          ph_next = PH_ARMED;
          at_load = 1'b1;
          pc_next = '0;
          ac_next = '0;
        end
      end
    endcase
  end

  assign rec_push   = q_pop && emit;
  assign rec.seg    = q_item.seg;
  assign rec.prompt = at;
  assign rec.dcount = rec_pc;
  assign rec.fcount = rec_ac;

  always_ff @(posedge clk) begin
    if (q_pop && at_load) begin
      armed_time[idx] <= q_item.ptime;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      near_start <= REG_W'(10000);
      near_end   <= REG_W'(502000);
      far_begin  <= REG_W'(2142000);
      far_limit  <= REG_W'(4110000);
      for (int i = 0; i < NSEG; i++) begin
        phase[i]  <= PH_IDLE;
        pcount[i] <= '0;
        acount[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_reg_e'(cfg_index))
          REG_NEAR_START: near_start <= cfg_data;
          REG_NEAR_END:   near_end   <= cfg_data;
          REG_FAR_BEGIN:  far_begin  <= cfg_data;
          REG_FAR_LIMIT:  far_limit  <= cfg_data;
          default: ;
        endcase
      end
      if (q_pop) begin
        phase[idx]  <= ph_next;
        pcount[idx] <= pc_next;
        acount[idx] <= ac_next;
      end
    end
  end

  // A closed candidate always had at least one delayed partner.
  a_rec_has_partner: assert property (@(posedge clk) disable iff (rst)
    rec_push |-> rec.dcount != '0)
    else $error("record emitted with zero delayed count");

  // Pulses earlier than the prompt never close a candidate.
  a_no_early_close: assert property (@(posedge clk) disable iff (rst)
    rec_push |-> !early)
    else $error("record emitted for a pulse before the prompt");

  // A far-phase pulse inside far_limit only counts, it never closes.
  a_far_inside_no_emit: assert property (@(posedge clk) disable iff (rst)
    (q_pop && ph == PH_FAR && !ge_fl) |-> !emit)
    else $error("far-phase pulse inside the window closed the candidate");

endmodule
